>>> src/flash_sector_write_planner_assert.svh
// Assertion macros for the sector write planner
`ifndef FLASH_SECTOR_WRITE_PLANNER_ASSERT_SVH
`define FLASH_SECTOR_WRITE_PLANNER_ASSERT_SVH
// Antecedent implies consequent on the same edge.
`define FSWP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Antecedent implies consequent on the next edge.
`define FSWP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> src/fswp_pkg.sv
// Package of the sector write planner: types and constants
package fswp_pkg;
	localparam int SECTOR_BYTES = 4096;
	localparam int PAGE_BYTES = 256;
	localparam int SEC_W = $clog2(SECTOR_BYTES);
	localparam int PAGE_W = $clog2(PAGE_BYTES);
	localparam int ADDR_W = 24;
	localparam int LEN_W = 13;
	localparam int CNT_W = 16;
	localparam logic [7:0] ERASED = 8'hFF;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_READ = 2'd1,
		ACT_DATA = 2'd2,
		ACT_ADV = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		CMD_READ = 3'd0,
		CMD_ERASE = 3'd1,
		CMD_HEADER = 3'd2,
		CMD_BYTE = 3'd3,
		CMD_DONE = 3'd4,
		CMD_ERROR = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE, PH_READ, PH_DATA, PH_PLAN, PH_HEADER, PH_BYTES, PH_NEXT, PH_FETCH
	} phase_t;
endpackage

>>> src/flash_sector_write_planner.sv
// Top level of the sector write planner
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | action start_address byte_count byte_value
//  out     | out_valid | out_stall | command_kind flash_address transfer_length
//          |           |           | program_byte page_end
// Read and data bytes give no command; the sector buffer
// is one RAM with one write and one registered read port. Other commands are
// loaded at the accepting edge and are valid the cycle after. A program byte
// is formed in steps: buffer read with command load, then the byte data load.
// Reset clears control state only; the buffer needs no clearing.
// A full output register, or a byte in flight, stalls input until it is taken.
module flash_sector_write_planner (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] action,
	input  logic [23:0] start_address,
	input  logic [15:0] byte_count,
	input  logic [7:0] byte_value,
	output logic out_valid,
	input  logic out_stall,
	output logic [2:0] command_kind,
	output logic [23:0] flash_address,
	output logic [12:0] transfer_length,
	output logic [7:0] program_byte,
	output logic page_end
);
	localparam int AW = fswp_pkg::ADDR_W;
	localparam int SW = fswp_pkg::SEC_W;
	localparam int LW = fswp_pkg::LEN_W;

	logic [7:0] mem [fswp_pkg::SECTOR_BYTES];
	logic [7:0] rd_q;
	logic we;
	logic [SW-1:0] waddr, raddr;
	logic [7:0] wdata;

	fswp_pkg::phase_t phase_q, phase_d;
	logic [AW-1:0] wcur_q, wcur_d, pcur_q, pcur_d;
	logic [15:0] left_q, left_d;
	logic [LW-1:0] clen_q, clen_d, bidx_q, bidx_d;
	logic erase_q, erase_d;
	logic fetch_last_q, fetch_last_d, fetch_pend_q, fetch_pend_d;

	logic ov_q;
	logic [2:0] kind_q;
	logic [AW-1:0] addr_q;
	logic [LW-1:0] len_q;
	logic [7:0] data_q;
	logic pend_q;

	logic emit;
	logic [2:0] e_kind;
	logic [AW-1:0] e_addr;
	logic [LW-1:0] e_len;
	logic e_pend;
	logic accept;

	logic [LW-1:0] off, room, cur_end, pidx, page_room, left13, hlen, newlen;
	logic [AW-1:0] sbase, nbase;
	logic [LW-1:0] nroom;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	assign in_stall = ov_q || (phase_q == fswp_pkg::PH_FETCH);
	assign accept = in_valid && !in_stall;

	assign off = LW'(wcur_q[SW-1:0]);
	assign sbase = {wcur_q[AW-1:SW], SW'(0)};
	assign cur_end = erase_q ? LW'(fswp_pkg::SECTOR_BYTES) : off + clen_q;
	assign pidx = LW'((pcur_q - sbase) & AW'(fswp_pkg::SECTOR_BYTES * 2 - 1));
	assign page_room = LW'(fswp_pkg::PAGE_BYTES) - LW'(pcur_q[fswp_pkg::PAGE_W-1:0]);
	// page room at the write cursor, for the first header of a chunk
	assign room = LW'(fswp_pkg::PAGE_BYTES) - LW'(wcur_q[fswp_pkg::PAGE_W-1:0]);
	assign left13 = cur_end - pidx;
	assign hlen = (left13 < page_room) ? left13 : page_room;
	assign raddr = pidx[SW-1:0];
	// chunk setup for start (new address) or next chunk (current cursor)
	assign nbase = (action == fswp_pkg::ACT_START) ? start_address : wcur_q;
	assign nroom = LW'(fswp_pkg::SECTOR_BYTES) - LW'(nbase[SW-1:0]);

	always_comb begin
		logic [15:0] cnt;
		cnt = (action == fswp_pkg::ACT_START) ? byte_count : left_q;
		newlen = (cnt < {3'b0, nroom}) ? LW'(cnt) : nroom;
	end

	always_comb begin
		phase_d = phase_q;
		wcur_d = wcur_q;
		pcur_d = pcur_q;
		left_d = left_q;
		clen_d = clen_q;
		bidx_d = bidx_q;
		erase_d = erase_q;
		fetch_last_d = fetch_last_q;
		fetch_pend_d = fetch_pend_q;
		if (phase_q == fswp_pkg::PH_FETCH) begin
			pcur_d = pcur_q + AW'(1);
			if (fetch_last_q) begin
				wcur_d = wcur_q + AW'(clen_q);
				left_d = left_q - 16'(clen_q);
				phase_d = fswp_pkg::PH_NEXT;
			end else if (fetch_pend_q)
				phase_d = fswp_pkg::PH_HEADER;
			else
				phase_d = fswp_pkg::PH_BYTES;
		end else if (accept) begin
			if (action == fswp_pkg::ACT_START) begin
				wcur_d = start_address;
				left_d = byte_count;
				pcur_d = '0;
				bidx_d = '0;
				erase_d = 1'b0;
				if (byte_count == 16'd0) begin
					phase_d = fswp_pkg::PH_IDLE;
					clen_d = '0;
				end else begin
					clen_d = newlen;
					phase_d = fswp_pkg::PH_READ;
				end
			end else if (action == fswp_pkg::ACT_READ && phase_q == fswp_pkg::PH_READ) begin
				if (bidx_q >= off && bidx_q < off + clen_q && byte_value != fswp_pkg::ERASED)
					erase_d = 1'b1;
				if (bidx_q == LW'(fswp_pkg::SECTOR_BYTES - 1)) begin
					bidx_d = '0;
					phase_d = fswp_pkg::PH_DATA;
				end else
					bidx_d = bidx_q + LW'(1);
			end else if (action == fswp_pkg::ACT_DATA && phase_q == fswp_pkg::PH_DATA) begin
				if (bidx_q + LW'(1) >= clen_q) begin
					bidx_d = '0;
					phase_d = fswp_pkg::PH_PLAN;
				end else
					bidx_d = bidx_q + LW'(1);
			end else if (action == fswp_pkg::ACT_ADV) begin
				case (phase_q)
					fswp_pkg::PH_PLAN: begin
						pcur_d = erase_q ? sbase : wcur_q;
						phase_d = erase_q ? fswp_pkg::PH_HEADER : fswp_pkg::PH_BYTES;
					end
					fswp_pkg::PH_HEADER: phase_d = fswp_pkg::PH_BYTES;
					fswp_pkg::PH_BYTES: begin
						fetch_last_d = (pidx + LW'(1) >= cur_end);
						fetch_pend_d = (pcur_q[fswp_pkg::PAGE_W-1:0] == '1);
						phase_d = fswp_pkg::PH_FETCH;
					end
					fswp_pkg::PH_NEXT: begin
						if (left_q == 16'd0)
							phase_d = fswp_pkg::PH_IDLE;
						else begin
							clen_d = newlen;
							erase_d = 1'b0;
							bidx_d = '0;
							phase_d = fswp_pkg::PH_READ;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// command formed for the accepted item (byte commands come from PH_FETCH)
	always_comb begin
		emit = 1'b0;
		e_kind = fswp_pkg::CMD_ERROR;
		e_addr = '0;
		e_len = '0;
		e_pend = 1'b0;
		we = 1'b0;
		waddr = bidx_q[SW-1:0];
		wdata = byte_value;
		if (phase_q == fswp_pkg::PH_FETCH) begin
			emit = 1'b1;
			e_kind = fswp_pkg::CMD_BYTE;
			e_addr = pcur_q;
			e_pend = fetch_last_q || fetch_pend_q;
		end else if (accept) begin
			emit = 1'b1;
			if (action == fswp_pkg::ACT_START) begin
				if (byte_count == 16'd0)
					e_kind = fswp_pkg::CMD_DONE;
				else begin
					e_kind = fswp_pkg::CMD_READ;
					e_addr = {start_address[AW-1:SW], SW'(0)};
					e_len = LW'(fswp_pkg::SECTOR_BYTES);
				end
			end else if (action == fswp_pkg::ACT_READ && phase_q == fswp_pkg::PH_READ) begin
				emit = 1'b0;
				we = 1'b1;
			end else if (action == fswp_pkg::ACT_DATA && phase_q == fswp_pkg::PH_DATA) begin
				emit = 1'b0;
				we = 1'b1;
				waddr = SW'(off + bidx_q);
			end else if (action == fswp_pkg::ACT_ADV) begin
				case (phase_q)
					fswp_pkg::PH_PLAN: begin
						if (erase_q) begin
							e_kind = fswp_pkg::CMD_ERASE;
							e_addr = sbase;
						end else begin
							e_kind = fswp_pkg::CMD_HEADER;
							e_addr = wcur_q;
							e_len = ((clen_q < room) ? clen_q : room);
						end
					end
					fswp_pkg::PH_HEADER: begin
						e_kind = fswp_pkg::CMD_HEADER;
						e_addr = pcur_q;
						e_len = hlen;
					end
					fswp_pkg::PH_BYTES: emit = 1'b0;
					fswp_pkg::PH_NEXT: begin
						if (left_q == 16'd0)
							e_kind = fswp_pkg::CMD_DONE;
						else begin
							e_kind = fswp_pkg::CMD_READ;
							e_addr = sbase;
							e_len = LW'(fswp_pkg::SECTOR_BYTES);
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fswp_pkg::PH_IDLE;
			wcur_q <= '0;
			pcur_q <= '0;
			left_q <= '0;
			clen_q <= '0;
			bidx_q <= '0;
			erase_q <= 1'b0;
			fetch_last_q <= 1'b0;
			fetch_pend_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			wcur_q <= wcur_d;
			pcur_q <= pcur_d;
			left_q <= left_d;
			clen_q <= clen_d;
			bidx_q <= bidx_d;
			erase_q <= erase_d;
			fetch_last_q <= fetch_last_d;
			fetch_pend_q <= fetch_pend_d;
			if (emit)
				ov_q <= 1'b1;
			else if (out_valid && !out_stall)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q <= e_kind;
			addr_q <= e_addr;
			len_q <= e_len;
			pend_q <= e_pend;
		end
	end

	// byte data arrives from the RAM in the cycle after the fetch
	logic byte_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			byte_s1 <= 1'b0;
		else
			byte_s1 <= (phase_q == fswp_pkg::PH_FETCH);
	end
	always_ff @(posedge clk) begin
		if (emit)
			data_q <= '0;
		else if (byte_s1)
			data_q <= rd_q;
	end

	assign out_valid = ov_q && !byte_s1;
	assign command_kind = kind_q;
	assign flash_address = addr_q;
	assign transfer_length = len_q;
	assign program_byte = data_q;
	assign page_end = pend_q;

`include "flash_sector_write_planner_assert.svh"

	`FSWP_ASSERT_IMP(a_no_emit_when_full, clk, arst_n, ov_q && !byte_s1 && out_stall, !emit,
		"command register overwritten")
	`FSWP_ASSERT_NEXT(a_fetch_one_cycle, clk, arst_n, phase_q == fswp_pkg::PH_FETCH,
		phase_q != fswp_pkg::PH_FETCH, "fetch lasted more than a cycle")
	`FSWP_ASSERT_IMP(a_no_write_on_output, clk, arst_n, we, !emit,
		"buffer write with a command")
endmodule
